// ===== hw/rtl/smgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Set gap and range package
// Sizes, handshake structs between controller and datapath, and the
// difference helper that the datapath uses.
// ----------------------------------------------------------------------------
package smgr_pkg;

   localparam int CAPACITY = 1024;
   localparam int VALUE_W  = 32;
   localparam int SIZE_W   = 11;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int LIMIT_W  = (COUNT_W > SIZE_W) ? COUNT_W : SIZE_W;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
      logic result;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic scan_done;
      logic out_free;
   } status_type;

   function automatic logic [VALUE_W-1:0] abs_diff(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
      logic [VALUE_W-1:0] ab;
      logic [VALUE_W-1:0] ba;
      ab = a - b;
      ba = b - a;
      return ($signed(a) < $signed(b)) ? ba : ab;
   endfunction

endpackage

// ===== hw/rtl/smgr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/smgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Set gap and range controller
// Per item: check fill limit, scan unless empty, commit unless full, report.
// ----------------------------------------------------------------------------
module smgr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  smgr_pkg::status_type status,
   output smgr_pkg::cmd_type    cmd
);
   import smgr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.full) begin
               state_in = ST_RESULT;
            end else if (status.empty) begin
               state_in = ST_COMMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.result = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/smgr_dp.sv =====
// ----------------------------------------------------------------------------
// Set gap and range datapath
// Holds the store, count, smallest gap, extremes, fill limit and result.
// ----------------------------------------------------------------------------
module smgr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  smgr_pkg::cmd_type             cmd,
   output smgr_pkg::status_type          status,
   input  logic [smgr_pkg::VALUE_W-1:0]  req_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [smgr_pkg::SIZE_W-1:0]   csr_max_size,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic [smgr_pkg::SIZE_W-1:0]   rsp_count,
   output logic                          rsp_spans_valid,
   output logic [smgr_pkg::VALUE_W-1:0]  rsp_shortest_span,
   output logic [smgr_pkg::VALUE_W-1:0]  rsp_longest_span
);
   import smgr_pkg::*;

   logic [SIZE_W-1:0]  max_size_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [VALUE_W-1:0] gap_ff;
   logic [VALUE_W-1:0] lo_ff;
   logic [VALUE_W-1:0] hi_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               full_ff;
   logic [COUNT_W-1:0] issue_ff;
   logic               s1_ff;
   logic               s2_ff;
   logic [VALUE_W-1:0] diff_ff;
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [SIZE_W-1:0]  rsp_count_ff;
   logic               rsp_spans_valid_ff;
   logic [VALUE_W-1:0] rsp_shortest_ff;
   logic [VALUE_W-1:0] rsp_longest_ff;

   logic [LIMIT_W-1:0] count_wide;
   logic [LIMIT_W-1:0] size_wide;
   logic [LIMIT_W-1:0] limit;
   logic               rd_en;
   logic [VALUE_W-1:0] rd_data;
   logic               spans_valid;
   logic               s1_in;
   logic [VALUE_W-1:0] diff_in;

   assign count_wide  = LIMIT_W'(count_ff);
   assign size_wide   = LIMIT_W'(max_size_ff);
   assign limit       = (size_wide > LIMIT_W'(CAPACITY)) ? LIMIT_W'(CAPACITY) : size_wide;
   assign rd_en       = cmd.scan && (issue_ff < count_ff);
   assign s1_in       = rd_en;
   assign diff_in     = abs_diff(rd_data, value_ff);
   assign spans_valid = count_wide >= LIMIT_W'(2);

   assign status.full      = full_ff;
   assign status.empty     = (count_ff == '0);
   assign status.scan_done = (issue_ff == count_ff) && !s1_ff && !s2_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign csr_ready = 1'b1;

   smgr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff  <= '0;
         count_ff     <= '0;
         gap_ff       <= '1;
         lo_ff        <= '0;
         hi_ff        <= '0;
         full_ff      <= 1'b0;
         issue_ff     <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_size_ff <= csr_max_size;
         end
         s1_ff <= s1_in;
         s2_ff <= s1_ff;
         if (cmd.load) begin
            full_ff  <= count_wide >= limit;
            issue_ff <= '0;
         end else if (rd_en) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (s2_ff && (diff_ff < gap_ff)) begin
            gap_ff <= diff_ff;
         end
         if (cmd.commit) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0) begin
               lo_ff <= value_ff;
               hi_ff <= value_ff;
            end else begin
               if ($signed(value_ff) < $signed(lo_ff)) begin
                  lo_ff <= value_ff;
               end
               if ($signed(hi_ff) < $signed(value_ff)) begin
                  hi_ff <= value_ff;
               end
            end
         end
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end
      diff_ff <= diff_in;
      if (cmd.result) begin
         rsp_status_ff      <= full_ff;
         rsp_count_ff       <= count_wide[SIZE_W-1:0];
         rsp_spans_valid_ff <= spans_valid;
         rsp_shortest_ff    <= spans_valid ? gap_ff : '0;
         rsp_longest_ff     <= spans_valid ? (hi_ff - lo_ff) : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_spans_valid   = rsp_spans_valid_ff;
   assign rsp_shortest_span = rsp_shortest_ff;
   assign rsp_longest_span  = rsp_longest_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_wide <= LIMIT_W'(CAPACITY))
      else $error("held count exceeds the store capacity");

   a_commit_step : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("held count did not advance by one on commit");

   a_extremes : assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> !($signed(hi_ff) < $signed(lo_ff)))
      else $error("highest held value is below the lowest");

   a_span_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spans_valid) |-> (rsp_shortest_span <= rsp_longest_span))
      else $error("shortest span exceeds longest span");

endmodule

// ===== hw/rtl/set_min_gap_and_range.sv =====
// ----------------------------------------------------------------------------
// Set smallest gap and range
// Collects signed numbers into a bounded store and reports, per item, the
// count, the smallest gap between held values and their full span.
//
//   Port group   Direction   Contents
//   req_         in          value to add
//   rsp_         out         status, count, spans_valid, shortest and longest span
//   csr_         in          max_size fill limit
//
// An accepted item is processed in order: the fill limit is checked, the store is
// read one entry per cycle while the values already held are scanned, the read
// pipeline drains, the value is committed, and the result is reported once free.
// The first value skips the scan, and a rejected item goes straight to the report.
// Reset clears the count, extremes and limit; the store needs no clearing.
// A new item is accepted while the previous result still waits on rsp_ready.
// ----------------------------------------------------------------------------
module set_min_gap_and_range (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [smgr_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic [smgr_pkg::SIZE_W-1:0]  rsp_count,
   output logic                         rsp_spans_valid,
   output logic [smgr_pkg::VALUE_W-1:0] rsp_shortest_span,
   output logic [smgr_pkg::VALUE_W-1:0] rsp_longest_span,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [smgr_pkg::SIZE_W-1:0]  csr_max_size
);
   import smgr_pkg::*;

   cmd_type    cmd;
   status_type status;

   smgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   smgr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_value         (req_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_size      (csr_max_size),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span)
   );

endmodule

// ===== tb/sv/tb_set_min_gap_and_range.sv =====
// ----------------------------------------------------------------------------
// Testbench for the set smallest gap and range block
// A queue of numbers feeds a clocked driver on the req_ channel. A clocked
// monitor on the rsp_ channel compares every report with a predicted one.
// Each prediction is made when the number is accepted, from a local copy of
// the held values, the smallest gap, the extremes and the fill limit.
// The run starts with short directed checks: rejection at a zero limit,
// fewer than two values held, and a limit lowered below the count. It then
// grows the set at several limits, the highest of them above the store capacity.
// Both sides idle at random, with one stretch where neither idles.
// ----------------------------------------------------------------------------
module tb_set_min_gap_and_range;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = smgr_pkg::CAPACITY;
   localparam int VALUE_W  = smgr_pkg::VALUE_W;
   localparam int SIZE_W   = smgr_pkg::SIZE_W;

   localparam logic STATUS_ACCEPTED = 1'b0;
   localparam logic STATUS_FULL     = 1'b1;

   localparam logic [SIZE_W-1:0] LIMIT_ALL_ONES = '1;

   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int SETTLE_CYCLES = CAPACITY + 64;
   localparam int MAX_REPORTS   = 40;

   typedef struct {
      logic [VALUE_W-1:0] value;
      bit                 wait_empty;
   } number_item_type;

   typedef struct {
      logic               status;
      logic [SIZE_W-1:0]  count;
      logic               spans_valid;
      logic [VALUE_W-1:0] shortest;
      logic [VALUE_W-1:0] longest;
   } report_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_status;
   logic [SIZE_W-1:0]  rsp_count;
   logic               rsp_spans_valid;
   logic [VALUE_W-1:0] rsp_shortest_span;
   logic [VALUE_W-1:0] rsp_longest_span;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [SIZE_W-1:0]  csr_max_size = '0;

   number_item_type    numbers_to_send[$];
   report_type         expected_reports[$];
   logic [VALUE_W-1:0] held_values[$];
   logic [VALUE_W-1:0] min_gap = '1;
   logic [VALUE_W-1:0] lowest = '0;
   logic [VALUE_W-1:0] highest = '0;
   logic [SIZE_W-1:0]  fill_limit = '0;

   int unsigned req_gap_pct = 11;
   int unsigned rsp_stall_pct = 11;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;

   set_min_gap_and_range dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_size      (csr_max_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic predict_report(input logic [VALUE_W-1:0] number);
      report_type  rep;
      int unsigned cap;
      longint      diff;
      cap = (fill_limit < CAPACITY) ? fill_limit : CAPACITY;
      rep.status = STATUS_FULL;
      if (held_values.size() < cap) begin
         rep.status = STATUS_ACCEPTED;
         foreach (held_values[i]) begin
            diff = longint'($signed(held_values[i])) - longint'($signed(number));
            if (diff < 0) begin
               diff = -diff;
            end
            if (diff[VALUE_W-1:0] < min_gap) begin
               min_gap = diff[VALUE_W-1:0];
            end
         end
         if (held_values.size() == 0) begin
            lowest = number;
            highest = number;
         end else begin
            if ($signed(number) < $signed(lowest)) begin
               lowest = number;
            end
            if ($signed(number) > $signed(highest)) begin
               highest = number;
            end
         end
         held_values = {held_values, number};
      end
      rep.count = SIZE_W'(held_values.size());
      rep.spans_valid = (held_values.size() >= 2);
      rep.shortest = rep.spans_valid ? min_gap : '0;
      rep.longest = rep.spans_valid ? highest - lowest : '0;
      expected_reports = {expected_reports, rep};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_value <= '0;
      end else begin
         if (req_valid && req_ready) begin
            predict_report(req_value);
            void'(numbers_to_send.pop_front());
         end
         if (!req_valid || req_ready) begin
            if (numbers_to_send.size() == 0 ||
                (numbers_to_send[0].wait_empty && expected_reports.size() != 0) ||
                $urandom_range(0, 99) < req_gap_pct) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_value <= numbers_to_send[0].value;
            end
         end
      end
   end

   task automatic compare_field(input string field, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: unexpected report, expected none, actual count %0d",
                           $time, rsp_count);
               end
            end else begin
               want = expected_reports.pop_front();
               compare_field("status", VALUE_W'(want.status), VALUE_W'(rsp_status));
               compare_field("count", VALUE_W'(want.count), VALUE_W'(rsp_count));
               compare_field("spans_valid", VALUE_W'(want.spans_valid),
                             VALUE_W'(rsp_spans_valid));
               compare_field("shortest_span", want.shortest, rsp_shortest_span);
               compare_field("longest_span", want.longest, rsp_longest_span);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("set_min_gap_and_range regression: fail");
         $finish;
      end
   end

   task automatic queue_number(input logic [VALUE_W-1:0] value, input bit wait_empty = 1'b0);
      number_item_type item;
      item.value = value;
      item.wait_empty = wait_empty;
      numbers_to_send = {numbers_to_send, item};
   endtask

   task automatic queue_random(input int count, input int unsigned reach,
                               input int unsigned cluster_pct);
      logic [VALUE_W-1:0] value;
      for (int n = 0; n < count; n++) begin
         if (held_values.size() != 0 && $urandom_range(0, 99) < cluster_pct) begin
            value = held_values[$urandom_range(0, held_values.size() - 1)] +
                    $urandom_range(1, 4096);
         end else if (reach == 0) begin
            value = $urandom;
         end else begin
            value = int'($urandom_range(0, 2 * reach)) - int'(reach);
         end
         queue_number(value, (n % 97) == 50);
      end
   endtask

   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (numbers_to_send.size() != 0 || req_valid || expected_reports.size() != 0);
   endtask

   task automatic write_fill_limit(input logic [SIZE_W-1:0] setting);
      wait_until_drained();
      csr_valid <= 1'b1;
      csr_max_size <= setting;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      fill_limit = setting;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_fill_limit('0);
      queue_number(32'h8000_0000);
      queue_number(32'h7fff_ffff);
      queue_number(32'h0000_0000);

      write_fill_limit(SIZE_W'(1));
      queue_number(-1000);
      queue_number(1);

      write_fill_limit(SIZE_W'(2));
      queue_number(3000);
      queue_number(-5);

      write_fill_limit(SIZE_W'(6));
      queue_number(500);
      queue_number(-3000);
      queue_number(2200);
      queue_number(10000);
      queue_number(77);

      write_fill_limit(SIZE_W'(3));
      queue_number(42);
      queue_number(-42);

      write_fill_limit(SIZE_W'(held_values.size() + 150));
      queue_random(150, 1 << 24, 0);
      queue_random(5, 1 << 24, 0);

      write_fill_limit(SIZE_W'(CAPACITY));
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      queue_random(250, 1 << 28, 3);

      write_fill_limit(LIMIT_ALL_ONES);
      req_gap_pct = 11;
      rsp_stall_pct = 11;
      queue_random(150, 0, 4);
      queue_number(32'h8000_0000, 1'b1);
      queue_number(32'h7fff_ffff);
      queue_number(held_values[$urandom_range(0, held_values.size() - 1)]);
      queue_random(6, 0, 0);

      write_fill_limit('0);
      queue_random(2, 0, 0);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_reports.size() == 0) begin
         $display("set_min_gap_and_range regression: pass");
      end else begin
         $display("set_min_gap_and_range regression: fail");
      end
      $finish;
   end

endmodule
